FILE: rtl/gsts_pkg.sv
// Shared types and constants for the three-equation Gauss-Seidel solver.
// No dependencies; compiled first.
package gsts_pkg;

    // Sum width: exact Q16.16 sums of up to three 33-bit terms
    localparam int SUM_W    = 35;
    // Quotient bits retired per divider cycle
    localparam int DIGITS   = 5;
    localparam int DIV_CYC  = SUM_W / DIGITS;
    localparam int DCNT_W   = $clog2(DIV_CYC);
    // Divisor width (constant divisors up to 7)
    localparam int DVSR_W   = 3;

    localparam int VAL_W    = 32;
    localparam int TOL_W    = 31;
    localparam int CNT_W    = 7;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [VAL_W-1:0] t_val;

    // Q16.16 equation constants
    localparam t_sum C_THREE = t_sum'(3) <<< 16;
    localparam t_sum C_NINE  = t_sum'(9) <<< 16;
    localparam t_sum C_MSIX  = -(t_sum'(6) <<< 16);

    // Divisors of the three equations
    localparam logic [DVSR_W-1:0] DIV_X = 3'd4;
    localparam logic [DVSR_W-1:0] DIV_Y = 3'd6;
    localparam logic [DVSR_W-1:0] DIV_Z = 3'd7;

    // Request to the shared constant divider
    typedef struct packed {
        logic                start;
        logic [SUM_W-1:0]    mag;
        logic [DVSR_W-1:0]   divisor;
    } t_div_req;

    // Answer from the shared constant divider
    typedef struct packed {
        logic                done;
        logic [SUM_W-1:0]    quot;
    } t_div_rsp;

endpackage

FILE: rtl/gsts_if.sv
// Valid/ready channel interfaces for the solver: initial guess in, sweep result out.
// Depends on nothing.
interface gsts_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] guess_x;
    logic signed [31:0] guess_y;
    logic signed [31:0] guess_z;

    modport source (output valid, guess_x, guess_y, guess_z, input ready);
    modport sink   (input valid, guess_x, guess_y, guess_z, output ready);
endinterface

interface gsts_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [6:0]         sweep_number;
    logic               last;
    logic               converged;

    modport source (output valid, value_x, value_y, value_z, sweep_number, last, converged,
                    input ready);
    modport sink   (input valid, value_x, value_y, value_z, sweep_number, last, converged,
                    output ready);
endinterface

FILE: rtl/gsts_cdiv.sv
// Shared iterative divider of an unsigned magnitude by a small constant.
// Restoring division, DIGITS quotient bits per cycle. Depends on gsts_pkg.
module gsts_cdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsts_pkg::t_div_req i_req,
    output gsts_pkg::t_div_rsp o_rsp
);
    import gsts_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]    r_work;   // dividend bits shift out, quotient bits shift in
    logic [DVSR_W-1:0]   r_rem;
    logic [DVSR_W-1:0]   r_div;

    logic [DIGITS-1:0]   n_qbits;
    logic [DVSR_W-1:0]   n_rem;

    // One cycle of restoring division: DIGITS narrow compare/subtract steps
    always_comb begin
        logic [DVSR_W:0] t;
        logic [DVSR_W:0] rem;
        rem = {1'b0, r_rem};
        for (int i = 0; i < DIGITS; i++) begin
            t = {rem[DVSR_W-1:0], r_work[SUM_W-1-i]};
            if (t >= {1'b0, r_div}) begin
                n_qbits[DIGITS-1-i] = 1'b1;
                rem = t - {1'b0, r_div};
            end else begin
                n_qbits[DIGITS-1-i] = 1'b0;
                rem = t;
            end
        end
        n_rem = rem[DVSR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.mag;
            r_div  <= i_req.divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= {r_work[SUM_W-DIGITS-1:0], n_qbits};
            r_rem  <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_work;

endmodule

FILE: rtl/gauss_seidel_three_equation_solver_core.sv
// Gauss-Seidel solver top level: sequencer, state registers and output item register.
// Depends on gsts_pkg, gsts_if (gsts_in_if, gsts_out_if) and gsts_cdiv.

// Each accepted guess starts a run of sweeps over x=(3+y+z)/4, y=(9+2x-z)/6,
// z=(-6+x-y)/7 in signed Q16.16, divisions truncating toward zero. Every sweep
// gives one result item; the run ends once all three absolute changes are at
// most the tolerance, or after MAX_SWEEPS sweeps. The three divisions of a sweep
// share one radix-32 constant divider; each one forms the sum, runs in the
// divider, picks up the quotient and checks the change, and then the sweep
// hands its item to the output register, waiting while the output side stalls;
// no new guess is taken until the run ends.
// The tolerance register may be written only while no run is in progress.
module gauss_seidel_three_equation_solver_core #(
    parameter int MAX_SWEEPS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [30:0]             i_cfg_data,
    gsts_in_if.sink                 i_in,
    gsts_out_if.source              o_out
);
    import gsts_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SWEEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_CHK,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_X,
        PH_Y,
        PH_Z
    } t_phase;

    t_state             r_state;
    t_phase             r_phase;
    logic [TOL_W-1:0]   r_tol;
    t_val               r_cx, r_cy, r_cz;
    t_val               r_nx, r_ny, r_nz;
    t_val               r_q;
    logic               r_neg;
    logic               r_met;
    logic [CNT_W-1:0]   r_count;

    logic               r_out_valid;
    t_val               r_ox, r_oy, r_oz;
    logic [CNT_W-1:0]   r_osweep;
    logic               r_olast;
    logic               r_oconv;

    t_sum               n_sum;
    logic [DVSR_W-1:0]  n_divisor;
    logic [SUM_W-1:0]   n_mag;
    t_val               n_qmag;
    t_val               n_old;
    logic signed [VAL_W:0] n_diff;
    logic [VAL_W:0]     n_adiff;
    logic               n_within;
    logic [CNT_W-1:0]   n_sweep;
    logic               n_fin;
    logic               n_slot;
    logic               n_emit;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    gsts_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sum and divisor of the equation for the current phase
    always_comb begin
        unique case (r_phase)
            PH_X: begin
                n_sum     = C_THREE + SUM_W'(r_cy) + SUM_W'(r_cz);
                n_divisor = DIV_X;
                n_old     = r_cx;
            end
            PH_Y: begin
                n_sum     = C_NINE + (SUM_W'(r_nx) <<< 1) - SUM_W'(r_cz);
                n_divisor = DIV_Y;
                n_old     = r_cy;
            end
            PH_Z: begin
                n_sum     = C_MSIX + SUM_W'(r_nx) - SUM_W'(r_ny);
                n_divisor = DIV_Z;
                n_old     = r_cz;
            end
            default: begin
                n_sum     = '0;
                n_divisor = DIV_X;
                n_old     = r_cx;
            end
        endcase
        n_mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    end

    assign div_req.start   = (r_state == S_LOAD);
    assign div_req.mag     = n_mag;
    assign div_req.divisor = n_divisor;

    // Quotient fits 32 signed bits; apply the sign mod 2^32
    assign n_qmag = div_rsp.quot[VAL_W-1:0];

    // Change of the freshly computed value against the previous sweep
    assign n_diff   = (VAL_W+1)'(r_q) - (VAL_W+1)'(n_old);
    assign n_adiff  = n_diff[VAL_W] ? (VAL_W+1)'(-n_diff) : (VAL_W+1)'(n_diff);
    assign n_within = (n_adiff <= (VAL_W+1)'(r_tol));

    assign n_sweep = r_count + 1'b1;
    assign n_fin   = r_met || (n_sweep >= CNT_MAX);
    assign n_slot  = !r_out_valid || o_out.ready;
    assign n_emit  = (r_state == S_EMIT) && n_slot;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // Sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_X;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_met       <= 1'b1;
        end else begin
            // Output register: load a new item or drop the one taken
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cx    <= i_in.guess_x;
                        r_cy    <= i_in.guess_y;
                        r_cz    <= i_in.guess_z;
                        r_count <= '0;
                        r_met   <= 1'b1;
                        r_phase <= PH_X;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_neg   <= n_sum[SUM_W-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_q     <= r_neg ? -n_qmag : n_qmag;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_met <= r_met & n_within;
                    unique case (r_phase)
                        PH_X: begin
                            r_nx    <= r_q;
                            r_phase <= PH_Y;
                            r_state <= S_LOAD;
                        end
                        PH_Y: begin
                            r_ny    <= r_q;
                            r_phase <= PH_Z;
                            r_state <= S_LOAD;
                        end
                        default: begin
                            r_nz    <= r_q;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_EMIT: begin
                    if (n_slot) begin
                        r_ox        <= r_nx;
                        r_oy        <= r_ny;
                        r_oz        <= r_nz;
                        r_osweep    <= n_sweep;
                        r_olast     <= n_fin;
                        r_oconv     <= n_fin && r_met;
                        r_cx        <= r_nx;
                        r_cy        <= r_ny;
                        r_cz        <= r_nz;
                        r_count     <= n_sweep;
                        r_met       <= 1'b1;
                        r_phase     <= PH_X;
                        r_state     <= n_fin ? S_IDLE : S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);

    assign o_out.valid        = r_out_valid;
    assign o_out.value_x      = r_ox;
    assign o_out.value_y      = r_oy;
    assign o_out.value_z      = r_oz;
    assign o_out.sweep_number = r_osweep;
    assign o_out.last         = r_olast;
    assign o_out.converged    = r_oconv;

endmodule

FILE: verif/gauss_seidel_three_equation_solver_core_checker.sv
`timescale 1ns / 100ps
// Sweep checker for the Gauss-Seidel solver: predicts every sweep result from each guess.
// Depends on gsts_pkg and the channel interfaces in gsts_if.
module gsts_sweep_checker #(
    parameter int MAX_SWEEPS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gsts_pkg::TOL_W-1:0]  i_cfg_data,
    gsts_in_if                          guess_ch,
    gsts_out_if                         sweep_ch,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_sweeps,
    output int                          o_runs_converged,
    output int                          o_runs_capped
);
    import gsts_pkg::*;

    // Q16.16 biases and divisors of the three update equations
    localparam longint BIAS_X = 3 * 65536;
    localparam longint BIAS_Y = 9 * 65536;
    localparam longint BIAS_Z = -6 * 65536;
    localparam longint DVSR_X = 4;
    localparam longint DVSR_Y = 6;
    localparam longint DVSR_Z = 7;
    localparam int     REPORT_MAX = 10;

    typedef struct {
        t_val              x;
        t_val              y;
        t_val              z;
        logic [CNT_W-1:0]  sweep;
        logic              last;
        logic              conv;
    } t_sweep_item;

    t_sweep_item        expected_sweeps[$];
    logic [TOL_W-1:0]   tolerance_q = 1;
    int                 errors = 0;
    int                 sweeps_seen = 0;
    int                 runs_converged = 0;
    int                 runs_capped = 0;

    function automatic longint abs_change(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Run the whole solve for one guess and queue one item per sweep
    function automatic void predict_sweeps(input t_val gx, input t_val gy, input t_val gz,
                                           input logic [TOL_W-1:0] tol);
        longint      cur_x, cur_y, cur_z;
        longint      nxt_x, nxt_y, nxt_z;
        longint      lim;
        bit          met;
        bit          fin;
        t_sweep_item item;
        cur_x = gx;
        cur_y = gy;
        cur_z = gz;
        lim   = longint'(tol);
        for (int n = 1; n <= MAX_SWEEPS; n++) begin
            // fresh values are used immediately (Gauss-Seidel order)
            nxt_x = (BIAS_X + cur_y + cur_z) / DVSR_X;
            nxt_y = (BIAS_Y + 2 * nxt_x - cur_z) / DVSR_Y;
            nxt_z = (BIAS_Z + nxt_x - nxt_y) / DVSR_Z;
            met = abs_change(nxt_x, cur_x) <= lim &&
                  abs_change(nxt_y, cur_y) <= lim &&
                  abs_change(nxt_z, cur_z) <= lim;
            fin = met || (n == MAX_SWEEPS);
            item.x     = t_val'(nxt_x);
            item.y     = t_val'(nxt_y);
            item.z     = t_val'(nxt_z);
            item.sweep = CNT_W'(n);
            item.last  = fin;
            item.conv  = fin && met;
            expected_sweeps.push_back(item);
            cur_x = nxt_x;
            cur_y = nxt_y;
            cur_z = nxt_z;
            if (fin) begin
                if (met)
                    runs_converged++;
                else
                    runs_capped++;
                break;
            end
        end
    endfunction

    // Outputs are checked before a new guess is queued: they belong to older runs
    always @(posedge i_clk) begin
        t_sweep_item want;
        logic        bad;
        if (!i_rst_n) begin
            tolerance_q = 1;
        end else begin
            if (sweep_ch.valid && sweep_ch.ready) begin
                sweeps_seen++;
                if (expected_sweeps.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: unexpected sweep item: sweep %0d x %h y %h z %h",
                                 $realtime, sweep_ch.sweep_number, sweep_ch.value_x,
                                 sweep_ch.value_y, sweep_ch.value_z);
                end else begin
                    want = expected_sweeps.pop_front();
                    bad  = (sweep_ch.value_x !== want.x) || (sweep_ch.value_y !== want.y) ||
                           (sweep_ch.value_z !== want.z) ||
                           (sweep_ch.sweep_number !== want.sweep) ||
                           (sweep_ch.last !== want.last) || (sweep_ch.converged !== want.conv);
                    if (bad) begin
                        errors++;
                        if (errors <= REPORT_MAX) begin
                            $display("%0t: expected x %h y %h z %h sw %0d l %b c %b",
                                     $realtime, want.x, want.y, want.z, want.sweep,
                                     want.last, want.conv);
                            $display("%0t: actual   x %h y %h z %h sw %0d l %b c %b",
                                     $realtime, sweep_ch.value_x, sweep_ch.value_y,
                                     sweep_ch.value_z, sweep_ch.sweep_number,
                                     sweep_ch.last, sweep_ch.converged);
                        end
                    end
                end
            end
            if (guess_ch.valid && guess_ch.ready)
                predict_sweeps(guess_ch.guess_x, guess_ch.guess_y, guess_ch.guess_z,
                               tolerance_q);
            if (i_cfg_we)
                tolerance_q = i_cfg_data;
        end
        o_pending        <= expected_sweeps.size();
        o_errors         <= errors;
        o_sweeps         <= sweeps_seen;
        o_runs_converged <= runs_converged;
        o_runs_capped    <= runs_capped;
    end

endmodule

FILE: verif/gauss_seidel_three_equation_solver_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Gauss-Seidel solver: clock, reset, guess, tolerance and stall stimulus.
// Depends on gsts_pkg, gsts_if, the solver core and gsts_sweep_checker.
module gauss_seidel_three_equation_solver_core_tb;
    import gsts_pkg::*;

    localparam int          SWEEP_LIMIT   = 64;
    localparam int          NUM_PHASES    = 6;
    localparam int          DRAIN_CYCLES  = 80;
    localparam int unsigned CYCLE_LIMIT   = 5_000_000;
    localparam t_val        SOL_X         = 32'sd65536;
    localparam t_val        SOL_Y         = 32'sd131072;
    localparam t_val        SOL_Z         = -32'sd65536;
    localparam t_val        VAL_MAX       = 32'sh7FFF_FFFF;
    localparam t_val        VAL_MIN       = 32'sh8000_0000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [TOL_W-1:0]  cfg_data;
    bit                no_idle;
    int                guesses_sent;
    int                errors;
    int                open_sweeps;
    int                sweeps_done;
    int                runs_converged;
    int                runs_capped;

    gsts_in_if  guess_ch ();
    gsts_out_if sweep_ch ();

    gauss_seidel_three_equation_solver_core #(
        .MAX_SWEEPS (SWEEP_LIMIT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (guess_ch),
        .o_out      (sweep_ch)
    );

    gsts_sweep_checker #(
        .MAX_SWEEPS (SWEEP_LIMIT)
    ) sweep_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .guess_ch         (guess_ch),
        .sweep_ch         (sweep_ch),
        .o_errors         (errors),
        .o_pending        (open_sweeps),
        .o_sweeps         (sweeps_done),
        .o_runs_converged (runs_converged),
        .o_runs_capped    (runs_capped)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one guess; optionally hold off until every pending sweep has come back
    task automatic send_guess(input t_val gx, input t_val gy, input t_val gz,
                              input bit hold_off);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (hold_off || gap != 0)
            guess_ch.valid <= 1'b0;
        if (hold_off) begin
            do @(posedge i_clk); while (open_sweeps != 0);
        end
        repeat (gap) @(posedge i_clk);
        guess_ch.valid   <= 1'b1;
        guess_ch.guess_x <= gx;
        guess_ch.guess_y <= gy;
        guess_ch.guess_z <= gz;
        do @(posedge i_clk); while (!guess_ch.ready);
        guesses_sent++;
    endtask

    // Tolerance changes only with the solver drained
    task automatic write_tolerance(input logic [TOL_W-1:0] tol);
        guess_ch.valid <= 1'b0;
        do @(posedge i_clk); while (open_sweeps != 0);
        cfg_we   <= 1'b1;
        cfg_data <= tol;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic t_val corner_value();
        case ($urandom_range(0, 4))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Mix of full-range, near-solution, scaled and corner guesses
    task automatic random_guess(output t_val gx, output t_val gy, output t_val gz);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            gx = $urandom;
            gy = $urandom;
            gz = $urandom;
        end else if (kind <= 6) begin
            gx = SOL_X + int'($urandom_range(0, 8192)) - 4096;
            gy = SOL_Y + int'($urandom_range(0, 8192)) - 4096;
            gz = SOL_Z + int'($urandom_range(0, 8192)) - 4096;
        end else if (kind <= 8) begin
            gx = t_val'($urandom) >>> $urandom_range(0, 24);
            gy = t_val'($urandom) >>> $urandom_range(0, 24);
            gz = t_val'($urandom) >>> $urandom_range(0, 24);
        end else begin
            gx = corner_value();
            gy = corner_value();
            gz = corner_value();
        end
    endtask

    // Result side: random stalls, with stall-free stretches
    initial begin
        int stall;
        sweep_ch.ready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                sweep_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            sweep_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!sweep_ch.valid);
        end
    end

    // Main stimulus
    initial begin
        logic [TOL_W-1:0] phase_tol [NUM_PHASES];
        int               phase_items;
        t_val             gx, gy, gz;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        guess_ch.valid   = 1'b0;
        guess_ch.guess_x = '0;
        guess_ch.guess_y = '0;
        guess_ch.guess_z = '0;
        no_idle          = 1'b0;
        guesses_sent     = 0;
        phase_tol = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'($urandom_range(2, 4096)),
                      31'h1_0000, 31'($urandom)};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed guesses at the reset tolerance
        send_guess('0, '0, '0, 1'b0);
        send_guess(SOL_X, SOL_Y, SOL_Z, 1'b0);
        send_guess(SOL_X + 1, SOL_Y + 1, SOL_Z + 1, 1'b0);
        send_guess(VAL_MAX, VAL_MAX, VAL_MAX, 1'b0);
        send_guess(VAL_MIN, VAL_MIN, VAL_MIN, 1'b0);
        send_guess(VAL_MAX, VAL_MIN, VAL_MAX, 1'b0);
        send_guess(VAL_MIN, VAL_MAX, VAL_MIN, 1'b0);
        send_guess(VAL_MIN, VAL_MIN, VAL_MAX, 1'b0);
        send_guess(VAL_MAX, '0, VAL_MIN, 1'b1);
        send_guess(-32'sd1, -32'sd1, -32'sd1, 1'b0);
        send_guess(32'sd1, 32'sd1, 32'sd1, 1'b0);
        send_guess(32'sh0000_FFFF, 32'shFFFF_0000, 32'sh5555_5555, 1'b0);
        send_guess(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0);

        // Random phases, one tolerance each; tolerance zero runs long, so keep it short
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_tolerance(phase_tol[ph]);
            phase_items = (phase_tol[ph] == '0) ? 25 : 85;
            for (int k = 0; k < phase_items; k++) begin
                no_idle = (k >= 20 && k < 35);
                random_guess(gx, gy, gz);
                send_guess(gx, gy, gz, k == 10);
            end
        end
        no_idle = 1'b0;
        guess_ch.valid <= 1'b0;

        // Drain, then watch for stray items
        do @(posedge i_clk); while (open_sweeps != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d guesses over %0d tolerance settings plus the reset value;",
                 guesses_sent, NUM_PHASES);
        $display("checked %0d sweep items, %0d runs converged, %0d stopped at the sweep cap.",
                 sweeps_done, runs_converged, runs_capped);
        if (errors == 0 && open_sweeps == 0)
            $display("gauss_seidel_three_equation_solver_core test passed");
        else
            $display("gauss_seidel_three_equation_solver_core test failed");
        $finish;
    end

    // Watchdog
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d sweep items still pending",
                 cycles, open_sweeps);
        $display("gauss_seidel_three_equation_solver_core test failed");
        $finish;
    end

endmodule
